@@ rtl/cas_pkg.sv @@
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types and constants for the cave smoothing step: grid size, counter
// widths and the structs passed between the line buffer, window and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

    // Grid geometry
    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);

    // Result and register widths
    localparam int COUNT_W   = 12;
    localparam int THRESH_W  = 4;
    localparam int NCOUNT_W  = 4;

    localparam logic [COUNT_W-1:0]  COUNT_MAX        = {COUNT_W{1'b1}};
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET  = 4'd5;
    localparam logic [NCOUNT_W-1:0] NEIGHBOR_TOTAL   = 4'd8;

    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [THRESH_W-1:0] thresh_t;
    typedef logic [NCOUNT_W-1:0] ncount_t;

    // Line buffer entry: bit 0 two rows above, bit 1 one row above
    typedef logic [1:0] lb_word_t;

    // Line buffer access request
    typedef struct packed {
        logic     rd_en;
        col_t     rd_addr;
        logic     wr_en;
        col_t     wr_addr;
        lb_word_t wr_data;
    } lb_req_t;

    // Window rule decision for the cell entering the window center
    typedef struct packed {
        logic next_is_wall;
        logic flip;
    } rule_t;

endpackage

`default_nettype wire

@@ rtl/cas_line_buffer.sv @@
// ----------------------------------------------------------------------------
// cas_line_buffer
// Two line buffers held as one memory of GRID_COLS two-bit entries, one
// entry per column. Registered read, single write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_line_buffer (
    input  wire logic              clk,
    input  wire cas_pkg::lb_req_t  req,
    output cas_pkg::lb_word_t      rd_data
);

    cas_pkg::lb_word_t mem [cas_pkg::GRID_COLS];
    cas_pkg::lb_word_t rd_data_reg;

    // Read and write the column memory
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/cas_window.sv @@
// ----------------------------------------------------------------------------
// cas_window
// 3x3 window of cells, shifted one column per transaction, with the
// eight-neighbor wall count and the flip rule for the center cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_window (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift_en,
    input  wire logic [2:0]        col_in,
    input  wire cas_pkg::thresh_t  threshold,
    output cas_pkg::rule_t         rule
);

    logic [8:0]        window_reg;
    logic [8:0]        window_next;
    logic [7:0]        neighbors;
    logic              center;
    cas_pkg::ncount_t  walls;
    cas_pkg::ncount_t  floors;

    // Shift the new column in, oldest column in the low bits
    assign window_next = {col_in, window_reg[8:3]};
    assign center      = window_next[4];
    assign neighbors   = {window_next[8:5], window_next[3:0]};

    // Count walls among the eight neighbors
    always_comb
    begin
        walls = '0;
        for (int k = 0; k < 8; k++)
        begin
            walls = walls + cas_pkg::ncount_t'(neighbors[k]);
        end
    end

    assign floors = cas_pkg::NEIGHBOR_TOTAL - walls;

    // Flip a wall with enough floor neighbors, or a floor with enough walls
    always_comb
    begin
        if (center)
        begin
            rule.flip = (floors >= threshold);
        end
        else
        begin
            rule.flip = (walls >= threshold);
        end
        rule.next_is_wall = center ^ rule.flip;
    end

    // Hold the window between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (shift_en)
        begin
            window_reg <= window_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cave_automaton_smoothing_step.sv @@
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_step
// One generation of the cave smoothing automaton over a raster cell stream.
// Emits each interior cell's next value one row and one column behind input.
// ----------------------------------------------------------------------------
//
//  channel | signals                                                               | dir
//  --------+-----------------------------------------------------------------------+----
//  input   | in_valid, in_ready, cell_is_wall                                      | in
//  result  | out_valid, out_ready, new_is_wall, cell_changed, change_count, last_of_frame | out
//  config  | cfg_wr_en, cfg_wr_data (flip_threshold)                               | in
//
//  One cell per clock sustained unless the result register stalls. The
//  accepting edge loads the cell into the window stage and reads its column
//  from the line buffer; a firing window stage shifts the window and loads
//  the result register. Reset clears the window, position counters and flip
//  total and sets the threshold to 5; the line buffer is not cleared. A
//  stalled result register holds the window stage, which holds the input.
//
`default_nettype none

module cave_automaton_smoothing_step (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire cas_pkg::thresh_t       cfg_wr_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   cell_is_wall,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        new_is_wall,
    output logic                        cell_changed,
    output cas_pkg::count_t             change_count,
    output logic                        last_of_frame
);

    // Configuration
    cas_pkg::thresh_t  flip_threshold_reg;

    // Input stage position
    cas_pkg::row_t     row_pos_reg;
    cas_pkg::col_t     col_pos_reg;

    // Window stage
    logic              s1_valid_reg;
    logic              s1_cell_reg;
    cas_pkg::row_t     s1_row_reg;
    cas_pkg::col_t     s1_col_reg;

    // Result register
    logic              out_valid_reg;
    logic              new_is_wall_reg;
    logic              cell_changed_reg;
    cas_pkg::count_t   change_count_reg;
    logic              last_of_frame_reg;

    cas_pkg::count_t   flip_total_reg;
    cas_pkg::count_t   flip_total_next;
    cas_pkg::count_t   flip_base;

    logic              in_fire;
    logic              s1_fire;
    logic              out_free;
    logic              s1_produces;
    logic              s1_frame_start;
    logic              s1_last;
    cas_pkg::lb_req_t  lb_req;
    cas_pkg::lb_word_t lb_rd_data;
    cas_pkg::rule_t    rule;

    // Handshake
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_threshold_reg <= cas_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            flip_threshold_reg <= cfg_wr_data;
        end
    end

    // Advance the raster position on each input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (in_fire)
        begin
            if (col_pos_reg == cas_pkg::col_t'(cas_pkg::GRID_COLS - 1))
            begin
                col_pos_reg <= '0;
                if (row_pos_reg == cas_pkg::row_t'(cas_pkg::GRID_ROWS - 1))
                begin
                    row_pos_reg <= '0;
                end
                else
                begin
                    row_pos_reg <= row_pos_reg + cas_pkg::row_t'(1);
                end
            end
            else
            begin
                col_pos_reg <= col_pos_reg + cas_pkg::col_t'(1);
            end
        end
    end

    // Window stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Window stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cell_reg <= cell_is_wall;
            s1_row_reg  <= row_pos_reg;
            s1_col_reg  <= col_pos_reg;
        end
    end

    // Read on input, write back the shifted column from the window stage
    always_comb
    begin
        lb_req.rd_en   = in_fire;
        lb_req.rd_addr = col_pos_reg;
        lb_req.wr_en   = s1_fire;
        lb_req.wr_addr = s1_col_reg;
        lb_req.wr_data = {s1_cell_reg, lb_rd_data[1]};
    end

    cas_line_buffer u_line_buffer (
        .clk     (clk),
        .req     (lb_req),
        .rd_data (lb_rd_data)
    );

    cas_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (s1_fire),
        .col_in    ({s1_cell_reg, lb_rd_data[1], lb_rd_data[0]}),
        .threshold (flip_threshold_reg),
        .rule      (rule)
    );

    // Interior test and frame boundaries
    assign s1_produces    = (s1_row_reg >= cas_pkg::row_t'(2)) &&
                            (s1_col_reg >= cas_pkg::col_t'(2));
    assign s1_frame_start = (s1_row_reg == '0) && (s1_col_reg == '0);
    assign s1_last        = (s1_row_reg == cas_pkg::row_t'(cas_pkg::GRID_ROWS - 1)) &&
                            (s1_col_reg == cas_pkg::col_t'(cas_pkg::GRID_COLS - 1));

    // Clear the total at frame start, count flips with saturation
    always_comb
    begin
        flip_base       = s1_frame_start ? '0 : flip_total_reg;
        flip_total_next = flip_base;
        if (s1_produces && rule.flip && (flip_base != cas_pkg::COUNT_MAX))
        begin
            flip_total_next = flip_base + cas_pkg::count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_total_reg <= '0;
        end
        else if (s1_fire)
        begin
            flip_total_reg <= flip_total_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && s1_produces;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_produces)
        begin
            new_is_wall_reg   <= rule.next_is_wall;
            cell_changed_reg  <= rule.flip;
            change_count_reg  <= flip_total_next;
            last_of_frame_reg <= s1_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_is_wall   = new_is_wall_reg;
    assign cell_changed  = cell_changed_reg;
    assign change_count  = change_count_reg;
    assign last_of_frame = last_of_frame_reg;

endmodule

`default_nettype wire

@@ rtl/cas_checker.sv @@
// ----------------------------------------------------------------------------
// cas_checker
// Port-level checks for the cave smoothing step, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_ready,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic             new_is_wall,
    input  wire logic             cell_changed,
    input  wire cas_pkg::count_t  change_count,
    input  wire logic             last_of_frame
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_is_wall) &&
        $stable(cell_changed) && $stable(change_count) && $stable(last_of_frame))
    else $error("stalled result changed");

    // A flipped cell is always counted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cell_changed |-> change_count != '0)
    else $error("flip reported with zero change count");

    // Count never drops between back-to-back results of one frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_frame) ##1 (out_valid && out_ready)
        |-> change_count >= $past(change_count))
    else $error("change count decreased within a frame");

    // Empty result register means the block takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind cave_automaton_smoothing_step cas_checker u_cas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_is_wall   (new_is_wall),
    .cell_changed  (cell_changed),
    .change_count  (change_count),
    .last_of_frame (last_of_frame)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams binary cave grids through the smoothing step cell by cell. A
// scoreboard tracks its own line buffers, window, raster position and flip
// total, predicts every interior result, and compares each result field by
// field. The threshold is rewritten between phases, with mixed idle and stall
// patterns on the input and result channels.
// ----------------------------------------------------------------------------

module tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;

    // One interior cell of the next generation
    typedef struct {
        logic            new_is_wall;
        logic            cell_changed;
        cas_pkg::count_t change_count;
        logic            last_of_frame;
    } smoothed_cell_t;

    // Next-generation predictor and store of pending interior cells
    class smoothing_scoreboard;
        logic             row_store [2*cas_pkg::GRID_COLS];
        logic [8:0]       window;
        int unsigned      row;
        int unsigned      col;
        cas_pkg::count_t  flip_total;
        cas_pkg::thresh_t threshold;
        smoothed_cell_t   expected_cells [$];
        int               mismatches;
        int               results_checked;
        int               flips_seen;
        int               frames_closed;

        function new();
            foreach (row_store[i]) row_store[i] = 1'b0;
            window          = '0;
            row             = 0;
            col             = 0;
            flip_total      = '0;
            threshold       = cas_pkg::THRESHOLD_RESET;
            mismatches      = 0;
            results_checked = 0;
            flips_seen      = 0;
            frames_closed   = 0;
        endfunction

        function void set_threshold(cas_pkg::thresh_t value);
            threshold = value;
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        // Shift one accepted cell into the window and predict its result
        function void note_cell(logic wall);
            logic           top;
            logic           mid;
            logic           center;
            logic           flip;
            int             walls;
            int             floors;
            smoothed_cell_t cell_out;
            if (row == 0 && col == 0)
                flip_total = '0;
            top = row_store[col];
            mid = row_store[cas_pkg::GRID_COLS + col];
            row_store[col]                      = mid;
            row_store[cas_pkg::GRID_COLS + col] = wall;
            window = {wall, mid, top, window[8:3]};

            if (row >= 2 && col >= 2) begin
                center = window[4];
                walls  = $countones(window) - int'(center);
                floors = int'(cas_pkg::NEIGHBOR_TOTAL) - walls;
                if (center)
                    flip = (floors >= int'(threshold));
                else
                    flip = (walls >= int'(threshold));
                if (flip && flip_total != cas_pkg::COUNT_MAX)
                    flip_total = flip_total + 1'b1;
                cell_out.new_is_wall   = center ^ flip;
                cell_out.cell_changed  = flip;
                cell_out.change_count  = flip_total;
                cell_out.last_of_frame = (row == cas_pkg::GRID_ROWS - 1 &&
                                          col == cas_pkg::GRID_COLS - 1);
                expected_cells = {expected_cells, cell_out};
            end

            // Advance the raster position, wrap at the end of the frame
            if (col + 1 >= cas_pkg::GRID_COLS) begin
                col = 0;
                row = (row + 1 >= cas_pkg::GRID_ROWS) ? 0 : row + 1;
            end
            else begin
                col = col + 1;
            end
        endfunction

        // Compare one result with the oldest pending cell
        function void check_result(logic nw, logic ch, cas_pkg::count_t cnt, logic last);
            smoothed_cell_t want;
            if (expected_cells.size() == 0) begin
                $error("result with none pending: new_is_wall %0d cell_changed %0d",
                       nw, ch);
                $error("  change_count %0d last_of_frame %0d", cnt, last);
                mismatches++;
                return;
            end
            want = expected_cells.pop_front();
            results_checked++;
            if (want.cell_changed)
                flips_seen++;
            if (want.last_of_frame)
                frames_closed++;
            if (nw !== want.new_is_wall) begin
                $error("new_is_wall: expected %0d, got %0d", want.new_is_wall, nw);
                mismatches++;
            end
            if (ch !== want.cell_changed) begin
                $error("cell_changed: expected %0d, got %0d", want.cell_changed, ch);
                mismatches++;
            end
            if (cnt !== want.change_count) begin
                $error("change_count: expected %0d, got %0d", want.change_count, cnt);
                mismatches++;
            end
            if (last !== want.last_of_frame) begin
                $error("last_of_frame: expected %0d, got %0d", want.last_of_frame, last);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    cas_pkg::thresh_t cfg_wr_data;
    logic             in_valid;
    logic             in_ready;
    logic             cell_is_wall;
    logic             out_valid;
    logic             out_ready;
    logic             new_is_wall;
    logic             cell_changed;
    cas_pkg::count_t  change_count;
    logic             last_of_frame;

    smoothing_scoreboard board;
    int sender_idle;
    int stall_pct;
    int hold_off_left;
    int cells_sent;
    int thresholds_used;
    int row_density;
    bit row_checker;
    int cycle_count;

    cave_automaton_smoothing_step uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cell_is_wall  (cell_is_wall),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .new_is_wall   (new_is_wall),
        .cell_changed  (cell_changed),
        .change_count  (change_count),
        .last_of_frame (last_of_frame)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: end the run if it hangs
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** cave_automaton_smoothing_step: FAILED **");
            $finish;
        end
    end

    // Result sink: random stalls, long hold-offs, check every transaction
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_left > 0) begin
                out_ready <= 1'b0;
                hold_off_left--;
            end
            else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(new_is_wall, cell_changed, change_count, last_of_frame);
        end
    end

    // Offer one cell, hold it until accepted; call and return at a falling edge
    task automatic send_cell(input logic wall);
        if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < sender_idle)
                @(negedge clk);
        end
        in_valid     <= 1'b1;
        cell_is_wall <= wall;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_cell(wall);
        cells_sent++;
        @(negedge clk);
    endtask

    // Pause the sender until every pending cell has come out, then settle
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input cas_pkg::thresh_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_threshold(value);
        thresholds_used++;
    endtask

    // Random grid content: each row gets its own wall density or a checkerboard
    task automatic run_phase(input cas_pkg::thresh_t thr, input bit write_cfg,
                             input int sidle, input int stall, input int hold,
                             input int items);
        logic wall;
        if (write_cfg) begin
            wait_for_drain();
            write_threshold(thr);
        end
        sender_idle   = sidle;
        stall_pct     = stall;
        hold_off_left = hold;
        for (int k = 0; k < items; k++) begin
            if (cells_sent % cas_pkg::GRID_COLS == 0) begin
                case ($urandom_range(8))
                    0: row_density = 0;
                    1: row_density = 8;
                    2: row_density = 35;
                    3: row_density = 45;
                    4: row_density = 55;
                    5: row_density = 65;
                    6: row_density = 92;
                    7: row_density = 100;
                    default: row_density = 50;
                endcase
                row_checker = ($urandom_range(8) == 8);
            end
            if (row_checker)
                wall = (((cells_sent % cas_pkg::GRID_COLS) +
                         (cells_sent / cas_pkg::GRID_COLS)) % 2) == 1;
            else
                wall = ($urandom_range(99) < row_density);
            send_cell(wall);
        end
    endtask

    initial
    begin
        logic [24:0] opening_row;
        board           = new();
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        cell_is_wall    = 1'b0;
        sender_idle     = 0;
        stall_pct       = 0;
        hold_off_left   = 0;
        cells_sent      = 0;
        thresholds_used = 1;
        row_density     = 50;
        row_checker     = 1'b0;
        opening_row     = 25'b1010101_1100110_00000_111111;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: runs of walls, floors and alternation on row 0,
        // which only fills the line buffers at the reset threshold
        for (int k = 0; k < 25; k++)
            send_cell(opening_row[k]);

        // Random rows under each idle pattern
        run_phase(cas_pkg::THRESHOLD_RESET, 1'b0, 0, 0, 0, 300);
        run_phase(4'd4, 1'b1, 81, 0, 0, 250);
        run_phase(4'd8, 1'b1, 0, 81, 0, 250);
        run_phase(4'd5, 1'b1, 32, 32, 0, 250);

        // Threshold zero: every interior cell flips; the sink holds off long
        // enough to back the block up into its input
        run_phase(4'd0, 1'b1, 0, 0, 400, 350);

        // Thresholds above eight never flip; then a low one
        run_phase(4'd15, 1'b1, 32, 32, 0, 150);
        run_phase(4'd9, 1'b1, 0, 81, 0, 150);
        run_phase(4'd3, 1'b1, 81, 0, 0, 125);

        wait_for_drain();

        $display("Sent %0d cells, checked %0d interior results with %0d flips",
                 cells_sent, board.results_checked, board.flips_seen);
        $display("Closed %0d frames across %0d threshold settings",
                 board.frames_closed, thresholds_used);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("** cave_automaton_smoothing_step: PASSED **");
        else
            $display("** cave_automaton_smoothing_step: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cas_pkg.sv
rtl/cas_line_buffer.sv
rtl/cas_window.sv
rtl/cave_automaton_smoothing_step.sv
rtl/cas_checker.sv
tb/tb.sv
